@@ rtl/tss_pkg.sv @@
// Package with shared constants and register indexes for the triangle span block.
`timescale 1ns / 1ps
package tss_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS = 24;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_A_X   = 3'd0,
    REG_A_Y   = 3'd1,
    REG_B_X   = 3'd2,
    REG_B_Y   = 3'd3,
    REG_C_X   = 3'd4,
    REG_C_Y   = 3'd5,
    REG_COLOR = 3'd6
  } cfg_reg_t;

  localparam int RST_A_X = 100;
  localparam int RST_A_Y = 600;
  localparam int RST_B_X = 100;
  localparam int RST_B_Y = 200;
  localparam int RST_C_X = 300;
  localparam int RST_C_Y = 400;
  localparam logic [COLOR_BITS-1:0] RST_COLOR = 24'hFF0000;

endpackage

@@ rtl/triangle_scanline_span.sv @@
// Top level: pipelined triangle scanline span with a bit-per-stage divider.
// An accepted item passes the setup, product and numerator registers and then the divider stages to the output.
// Throughput is one item per cycle; each stage holds one item and stalls only when
// the next stage is full and not moving.
// Synchronous active-high reset empties the pipeline and loads the vertex
// and color registers with their reset values; the sorted vertex set is registered from them in the cycle after.
`timescale 1ns / 1ps
module triangle_scanline_span #(
  parameter int COORD_BITS = tss_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tss_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tss_pkg::COLOR_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_BITS-1:0]         row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          in_span,
  output logic                          degenerate,
  output logic [COORD_BITS-1:0]         x_start,
  output logic [COORD_BITS-1:0]         x_end,
  output logic [tss_pkg::COLOR_BITS-1:0] span_color
);
  import tss_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int NS = CB + 3;

  typedef struct packed {
    logic          in_tri;
    logic          degen;
    logic [CB-1:0] px1, qx1, h1, l1, dy1;
    logic [CB-1:0] px2, qx2, h2, l2, dy2;
  } setup_t;

  typedef struct packed {
    logic            in_tri;
    logic            degen;
    logic [2*CB-1:0] pa1, pb1, pa2, pb2;
    logic [CB-1:0]   dy1, dy2;
  } prod_t;

  typedef struct packed {
    logic          in_tri;
    logic          degen;
    logic [CB-1:0] dy1, rem1, lo1, q1;
    logic [CB-1:0] dy2, rem2, lo2, q2;
  } div_t;

  logic [CB-1:0] ax, ay, bx, by, cx, cy;
  logic [COLOR_BITS-1:0] color;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= CB'(RST_A_X);
      ay <= CB'(RST_A_Y);
      bx <= CB'(RST_B_X);
      by <= CB'(RST_B_Y);
      cx <= CB'(RST_C_X);
      cy <= CB'(RST_C_Y);
      color <= RST_COLOR;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_A_X:   ax <= cfg_data[CB-1:0];
        REG_A_Y:   ay <= cfg_data[CB-1:0];
        REG_B_X:   bx <= cfg_data[CB-1:0];
        REG_B_Y:   by <= cfg_data[CB-1:0];
        REG_C_X:   cx <= cfg_data[CB-1:0];
        REG_C_Y:   cy <= cfg_data[CB-1:0];
        REG_COLOR: color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Vertices sorted by Y, refreshed every cycle from the registers.
  logic [CB-1:0] tx, ty, mx, my, bbx, bby;
  logic [CB-1:0] tx_next, ty_next, mx_next, my_next, bbx_next, bby_next;
  logic          degen_cfg, degen_cfg_next;

  always_comb begin
    logic [CB-1:0] t0x, t0y, t1x, t1y, t2x, t2y, sx, sy;
    t0x = ax; t0y = ay; t1x = bx; t1y = by; t2x = cx; t2y = cy;
    sx = '0; sy = '0;
    if (t1y < t0y) begin
      sx = t0x; sy = t0y; t0x = t1x; t0y = t1y; t1x = sx; t1y = sy;
    end
    if (t2y < t1y) begin
      sx = t1x; sy = t1y; t1x = t2x; t1y = t2y; t2x = sx; t2y = sy;
    end
    if (t1y < t0y) begin
      sx = t0x; sy = t0y; t0x = t1x; t0y = t1y; t1x = sx; t1y = sy;
    end
    tx_next = t0x; ty_next = t0y;
    mx_next = t1x; my_next = t1y;
    bbx_next = t2x; bby_next = t2y;
    degen_cfg_next = (ay == by) || (ay == cy) || (by == cy);
  end

  always_ff @(posedge clk) begin
    tx <= tx_next; ty <= ty_next;
    mx <= mx_next; my <= my_next;
    bbx <= bbx_next; bby <= bby_next;
    degen_cfg <= degen_cfg_next;
  end

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  setup_t s1, s1_next;
  always_comb begin
    s1_next = '0;
    s1_next.degen = degen_cfg;
    s1_next.in_tri = !degen_cfg && (row >= ty) && (row <= bby);
    s1_next.dy1 = CB'(1);
    s1_next.dy2 = CB'(1);
    if (s1_next.in_tri) begin
      s1_next.px1 = tx;
      s1_next.qx1 = bbx;
      s1_next.h1 = bby - row;
      s1_next.l1 = row - ty;
      s1_next.dy1 = bby - ty;
      if (row < my) begin
        s1_next.px2 = tx;
        s1_next.qx2 = mx;
        s1_next.h2 = my - row;
        s1_next.l2 = row - ty;
        s1_next.dy2 = my - ty;
      end else begin
        s1_next.px2 = mx;
        s1_next.qx2 = bbx;
        s1_next.h2 = bby - row;
        s1_next.l2 = row - my;
        s1_next.dy2 = bby - my;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) s1 <= s1_next;
  end

  prod_t s2;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2.in_tri <= s1.in_tri;
      s2.degen <= s1.degen;
      s2.pa1 <= (2*CB)'(s1.px1) * (2*CB)'(s1.h1);
      s2.pb1 <= (2*CB)'(s1.qx1) * (2*CB)'(s1.l1);
      s2.pa2 <= (2*CB)'(s1.px2) * (2*CB)'(s1.h2);
      s2.pb2 <= (2*CB)'(s1.qx2) * (2*CB)'(s1.l2);
      s2.dy1 <= s1.dy1;
      s2.dy2 <= s1.dy2;
    end
  end

  div_t dv [CB+1];
  logic [2*CB-1:0] num1, num2;
  assign num1 = s2.pa1 + s2.pb1;
  assign num2 = s2.pa2 + s2.pb2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dv[0].in_tri <= s2.in_tri;
      dv[0].degen <= s2.degen;
      dv[0].dy1 <= s2.dy1;
      dv[0].rem1 <= num1[2*CB-1:CB];
      dv[0].lo1 <= num1[CB-1:0];
      dv[0].q1 <= '0;
      dv[0].dy2 <= s2.dy2;
      dv[0].rem2 <= num2[2*CB-1:CB];
      dv[0].lo2 <= num2[CB-1:0];
      dv[0].q2 <= '0;
    end
  end

  function automatic div_t div_step(div_t d);
    div_t r;
    logic [CB:0] t1, t2;
    r = d;
    t1 = {d.rem1, d.lo1[CB-1]};
    t2 = {d.rem2, d.lo2[CB-1]};
    r.lo1 = {d.lo1[CB-2:0], 1'b0};
    r.lo2 = {d.lo2[CB-2:0], 1'b0};
    if (t1 >= {1'b0, d.dy1}) begin
      r.rem1 = CB'(t1 - {1'b0, d.dy1});
      r.q1 = {d.q1[CB-2:0], 1'b1};
    end else begin
      r.rem1 = t1[CB-1:0];
      r.q1 = {d.q1[CB-2:0], 1'b0};
    end
    if (t2 >= {1'b0, d.dy2}) begin
      r.rem2 = CB'(t2 - {1'b0, d.dy2});
      r.q2 = {d.q2[CB-2:0], 1'b1};
    end else begin
      r.rem2 = t2[CB-1:0];
      r.q2 = {d.q2[CB-2:0], 1'b0};
    end
    return r;
  endfunction

  for (genvar i = 0; i < CB; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rdy[i+3]) dv[i+1] <= div_step(dv[i]);
    end
  end

  assign out_valid = vld[NS-1];
  assign in_span = dv[CB].in_tri;
  assign degenerate = dv[CB].degen;
  assign x_start = dv[CB].q1;
  assign x_end = dv[CB].q2;
  assign span_color = color;

endmodule

@@ rtl/tss_checker.sv @@
// Port-level checker for the triangle span block, bound to the top level.
`timescale 1ns / 1ps
module tss_checker #(
  parameter int COORD_BITS = tss_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  in_span,
  input logic                  degenerate,
  input logic [COORD_BITS-1:0] x_start,
  input logic [COORD_BITS-1:0] x_end
);
  import tss_pkg::*;

  a_degen_no_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !in_span)
    else $error("Degenerate item reported inside a span.");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_span |-> (x_start == '0) && (x_end == '0))
    else $error("Item outside the span has nonzero X.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_start) && $stable(x_end))
    else $error("Stalled output item changed.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid right after reset.");

endmodule

bind triangle_scanline_span tss_checker #(.COORD_BITS(COORD_BITS)) u_tss_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .in_span(in_span), .degenerate(degenerate), .x_start(x_start), .x_end(x_end)
);

@@ tb/tb_top.sv @@
// Testbench for the triangle scanline span block: random rows and vertex sets, scoreboard check.
`timescale 1ns / 1ps
module tb_top;
  import tss_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int LIMIT = 4000;

  typedef struct packed {
    logic          in_tri;
    logic          degen;
    logic [CB-1:0] xs;
    logic [CB-1:0] xe;
    logic [COLOR_BITS-1:0] col;
  } span_t;

  class span_scoreboard;
    logic [CB-1:0] vx[3];
    logic [CB-1:0] vy[3];
    logic [COLOR_BITS-1:0] color;
    span_t spans_due[$];
    int errors;

    function new();
      vx = '{CB'(RST_A_X), CB'(RST_B_X), CB'(RST_C_X)};
      vy = '{CB'(RST_A_Y), CB'(RST_B_Y), CB'(RST_C_Y)};
      color = RST_COLOR;
      errors = 0;
    endfunction

    function void write(cfg_reg_t idx, logic [COLOR_BITS-1:0] val);
      case (idx)
        REG_A_X: vx[0] = val[CB-1:0];
        REG_A_Y: vy[0] = val[CB-1:0];
        REG_B_X: vx[1] = val[CB-1:0];
        REG_B_Y: vy[1] = val[CB-1:0];
        REG_C_X: vx[2] = val[CB-1:0];
        REG_C_Y: vy[2] = val[CB-1:0];
        REG_COLOR: color = val;
        default: ;
      endcase
    endfunction

    function logic [CB-1:0] edge_x(int px, int py, int qx, int qy, int r);
      int unsigned num;
      num = px * (qy - r) + qx * (r - py);
      return CB'(num / (qy - py));
    endfunction

    function void note_row(logic [CB-1:0] r);
      span_t s;
      int tx, ty, mx, my, bx, by, t, ri;
      s = '0;
      s.col = color;
      ri = int'(r);
      if (vy[0] == vy[1] || vy[0] == vy[2] || vy[1] == vy[2]) begin
        s.degen = 1'b1;
      end else begin
        tx = int'(vx[0]); ty = int'(vy[0]); mx = int'(vx[1]); my = int'(vy[1]);
        bx = int'(vx[2]); by = int'(vy[2]);
        if (my < ty) begin t = tx; tx = mx; mx = t; t = ty; ty = my; my = t; end
        if (by < my) begin t = mx; mx = bx; bx = t; t = my; my = by; by = t; end
        if (my < ty) begin t = tx; tx = mx; mx = t; t = ty; ty = my; my = t; end
        if (ri >= ty && ri <= by) begin
          s.in_tri = 1'b1;
          s.xs = edge_x(tx, ty, bx, by, ri);
          s.xe = (ri < my) ? edge_x(tx, ty, mx, my, ri) : edge_x(mx, my, bx, by, ri);
        end
      end
      spans_due.push_back(s);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_span(span_t got);
      span_t want;
      if (spans_due.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = spans_due.pop_front();
      if (got.in_tri !== want.in_tri)
        report($sformatf("in_span %0d want %0d", got.in_tri, want.in_tri));
      if (got.degen !== want.degen)
        report($sformatf("degenerate %0d want %0d", got.degen, want.degen));
      if (got.xs !== want.xs) report($sformatf("x_start %0d want %0d", got.xs, want.xs));
      if (got.xe !== want.xe) report($sformatf("x_end %0d want %0d", got.xe, want.xe));
      if (got.col !== want.col) report($sformatf("span_color %h want %h", got.col, want.col));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COLOR_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CB-1:0] row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic in_span, degenerate;
  logic [CB-1:0] x_start, x_end;
  logic [COLOR_BITS-1:0] span_color;

  span_scoreboard sb = new();
  bit no_idle = 1'b0;
  int quiet = 0;
  int stall_left = 0;

  triangle_scanline_span u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .row,
    .out_valid, .out_ready, .in_span, .degenerate, .x_start, .x_end, .span_color
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function int pick_gap();
    int p;
    if (no_idle) return 0;
    p = int'($urandom_range(0, 99));
    if (p < 60) return 0;
    if (p < 95) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_row(row);
      if (out_valid && out_ready)
        sb.check_span('{in_span, degenerate, x_start, x_end, span_color});
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  task send_row(logic [CB-1:0] r);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    row <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.spans_due.size() != 0) @(posedge clk);
    repeat (CB + 8) @(posedge clk);
  endtask

  task cfg_write(cfg_reg_t idx, logic [COLOR_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write(idx, val);
  endtask

  task load_vertices(int ax, int ay, int bx, int by, int cx, int cy,
                     logic [COLOR_BITS-1:0] col);
    cfg_write(REG_A_X, COLOR_BITS'(ax));
    cfg_write(REG_A_Y, COLOR_BITS'(ay));
    cfg_write(REG_B_X, COLOR_BITS'(bx));
    cfg_write(REG_B_Y, COLOR_BITS'(by));
    cfg_write(REG_C_X, COLOR_BITS'(cx));
    cfg_write(REG_C_Y, COLOR_BITS'(cy));
    cfg_write(REG_COLOR, col);
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(negedge clk);
  endtask

  task run_rows(int n, bit directed);
    int lo, hi, md;
    lo = int'(sb.vy[0]); hi = int'(sb.vy[0]);
    for (int i = 1; i < 3; i++) begin
      if (int'(sb.vy[i]) < lo) lo = int'(sb.vy[i]);
      if (int'(sb.vy[i]) > hi) hi = int'(sb.vy[i]);
    end
    md = int'(sb.vy[0]) + int'(sb.vy[1]) + int'(sb.vy[2]) - lo - hi;
    if (directed) begin
      send_row('0); send_row({CB{1'b1}}); send_row(CB'(lo)); send_row(CB'(hi));
      send_row(CB'(md));
      send_row(CB'(md - 1)); send_row(CB'(lo - 1)); send_row(CB'(hi + 1));
    end
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) send_row(CB'($urandom_range(lo, hi)));
      else send_row(CB'($urandom_range(0, (1 << CB) - 1)));
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(negedge clk);
    run_rows(40, 1'b1);
    load_vertices(0, 0, 4095, 4095, 4095, 2000, 24'hFFFFFF);
    cfg_write(cfg_reg_t'(7), 24'h00ABCD);
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(negedge clk);
    run_rows(50, 1'b1);
    load_vertices(4095, 0, 0, 4095, 0, 1, 24'h000000);
    run_rows(50, 1'b1);
    load_vertices(500, 300, 900, 300, 10, 800, 24'h123456);
    run_rows(20, 1'b1);
    for (int k = 0; k < 6; k++) begin
      load_vertices($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    COLOR_BITS'($urandom));
      run_rows(60, 1'b0);
    end
    if (sb.errors == 0 && sb.spans_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/tss_pkg.sv
rtl/triangle_scanline_span.sv
rtl/tss_checker.sv
tb/tb_top.sv
